/* design/set_pkg.sv */
// Package for sorted_event_table: field widths, request kinds, status codes, entry type.
// No dependencies.
`timescale 1ns / 1ps
package set_pkg;
  localparam int unsigned KeyW = 34;
  localparam int unsigned DayShift = 11;
  localparam int unsigned DefDepth = 32;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_LIST   = 3'd1,
    KIND_DAY    = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_MODIFY = 3'd4,
    KIND_DELETE = 3'd5,
    KIND_CLEAR  = 3'd6,
    KIND_NONE   = 3'd7
  } kind_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [31:0]     code;
    logic [31:0]     dur;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
endpackage

/* design/sorted_event_table.sv */
// Sorted event table: up to DEPTH events kept in key order in one RAM. Every request but
// clear, none and an insert on a full table walks the table through a single read port:
// each stored entry is read, then compared or moved. Finds, modifies, deletes and day
// searches share one key comparator; inserts use an ordering compare of their own, and
// inserts and deletes move entries one step at a time. Lists and
// day searches also stall on each result that waits. The block takes no new transfer
// until the last result of a request is taken. Uses set_pkg and set_ram.
`timescale 1ns / 1ps
module sorted_event_table
  import set_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
  //        event_code[65:34], duration_word[97:66], zero pad to 104
  input  logic [103:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_code[31:0], out_year[45:32], out_month[49:46], out_day[54:50],
  //        out_hour[59:55], out_minute[65:60], out_duration[97:66], zero pad to 104
  output logic [103:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,  // status
  output logic         m_axis_tlast
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_SHIFT_R, S_SHIFT_W, S_PUT, S_OUT, S_DEL_R, S_DEL_W
  } state_e;

  state_e          state_q;
  kind_e           kind_q;
  logic [KeyW-1:0] key_q;
  logic [31:0]     code_q, dur_q;
  logic [CW-1:0]   cnt_q, idx_q, pos_q;
  logic            pend_q;
  entry_t          pend_ent_q;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;

  // Result register
  logic            ov_q, olast_q;
  logic [1:0]      ost_q;
  entry_t          oent_q;

  set_ram #(.Width(EntryW), .Depth(DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [KeyW-1:0] in_key;
  assign in_key = {s_axis_tdata[13:0], s_axis_tdata[17:14], s_axis_tdata[22:18],
                   s_axis_tdata[27:23], s_axis_tdata[33:28]};

  logic out_free, match, out_load;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  // shared comparator: equality on exact key or on the day prefix
  assign match = (kind_q == KIND_DAY) ?
                 (rdata.key[KeyW-1:DayShift] == key_q[KeyW-1:DayShift]) :
                 (rdata.key == key_q);

  // load the result register this cycle
  assign out_load =
    (state_q == S_IDLE && s_axis_tvalid && s_axis_tready &&
     ((kind_e'(s_axis_tuser) == KIND_INSERT && cnt_q == CW'(DEPTH)) ||
      kind_e'(s_axis_tuser) == KIND_CLEAR)) ||
    (state_q == S_SCAN && idx_q >= cnt_q && kind_q != KIND_INSERT && out_free) ||
    (state_q == S_SCAN_W && (kind_q == KIND_LIST || (kind_q == KIND_DAY && match)) &&
     pend_q && out_free) ||
    ((state_q == S_PUT || state_q == S_OUT) && out_free);

  always_comb begin
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    raddr = idx_q[AW-1:0];
    unique case (state_q)
      S_SHIFT_W: begin
        we = 1'b1;
        waddr = AW'(idx_q + CW'(1));
      end
      S_PUT: begin
        we = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = '{key: key_q, code: code_q, dur: dur_q};
      end
      S_OUT: begin
        we = (kind_q == KIND_MODIFY);
        waddr = pos_q[AW-1:0];
        wdata = pend_ent_q;
      end
      S_DEL_W: begin
        we = 1'b1;
        waddr = AW'(idx_q - CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      ov_q <= out_load || (ov_q && !m_axis_tready);
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q <= kind_e'(s_axis_tuser);
            key_q  <= in_key;
            code_q <= s_axis_tdata[65:34];
            dur_q  <= s_axis_tdata[97:66];
            idx_q  <= '0;
            pend_q <= 1'b0;
            unique case (kind_e'(s_axis_tuser))
              KIND_INSERT: begin
                if (cnt_q == CW'(DEPTH)) begin
                  ost_q <= StFull; oent_q <= '0; olast_q <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              KIND_CLEAR: begin
                cnt_q <= '0;
                ost_q <= StOk; oent_q <= '0; olast_q <= 1'b1;
              end
              KIND_NONE: ;
              default: state_q <= S_SCAN;
            endcase
          end
        end
        // issue read of idx_q
        S_SCAN: begin
          if (idx_q >= cnt_q) begin
            // end of table
            if (kind_q == KIND_INSERT) begin
              pos_q <= idx_q;
              idx_q <= (cnt_q == '0) ? '0 : cnt_q - CW'(1);
              state_q <= (cnt_q == '0) ? S_PUT : S_SHIFT_R;
            end else if (out_free) begin
              if (pend_q) begin
                ost_q <= StOk; oent_q <= pend_ent_q; olast_q <= 1'b1;
              end else begin
                ost_q <= StMiss; oent_q <= '0; olast_q <= 1'b1;
              end
              pend_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          if (kind_q == KIND_INSERT) begin
            if (rdata.key >= key_q) begin
              pos_q <= idx_q;
              idx_q <= cnt_q - CW'(1);
              state_q <= S_SHIFT_R;
            end else begin
              idx_q <= idx_q + CW'(1);
              state_q <= S_SCAN;
            end
          end else if (kind_q == KIND_LIST || kind_q == KIND_DAY) begin
            if (kind_q == KIND_LIST || match) begin
              // hold one hit back so the last one can carry tlast
              if (!pend_q || out_free) begin
                if (pend_q) begin
                  ost_q <= StOk; oent_q <= pend_ent_q; olast_q <= 1'b0;
                end
                pend_q <= 1'b1;
                pend_ent_q <= rdata;
                idx_q <= idx_q + CW'(1);
                state_q <= S_SCAN;
              end
            end else begin
              idx_q <= idx_q + CW'(1);
              state_q <= S_SCAN;
            end
          end else begin
            if (match) begin
              pos_q <= idx_q;
              pend_ent_q <= '{key: rdata.key, code: rdata.code,
                              dur: (kind_q == KIND_MODIFY) ? dur_q : rdata.dur};
              state_q <= S_OUT;
            end else begin
              idx_q <= idx_q + CW'(1);
              state_q <= S_SCAN;
            end
          end
        end
        // move entry idx_q up by one, walking down to pos_q
        S_SHIFT_R: begin
          if (idx_q < pos_q || idx_q >= cnt_q) begin
            state_q <= S_PUT;
          end else begin
            state_q <= S_SHIFT_W;
          end
        end
        S_SHIFT_W: begin
          if (idx_q == pos_q) begin
            state_q <= S_PUT;
          end else begin
            idx_q <= idx_q - CW'(1);
            state_q <= S_SHIFT_R;
          end
        end
        S_PUT: begin
          if (out_free) begin
            cnt_q <= cnt_q + CW'(1);
            ost_q <= StOk; olast_q <= 1'b1;
            oent_q <= '{key: key_q, code: code_q, dur: dur_q};
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ost_q <= StOk; olast_q <= 1'b1; oent_q <= pend_ent_q;
            if (kind_q == KIND_DELETE) begin
              idx_q <= pos_q + CW'(1);
              state_q <= S_DEL_R;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        // pull entry idx_q down by one
        S_DEL_R: begin
          if (idx_q >= cnt_q) begin
            cnt_q <= cnt_q - CW'(1);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DEL_W;
          end
        end
        S_DEL_W: begin
          idx_q <= idx_q + CW'(1);
          state_q <= S_DEL_R;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {6'd0, oent_q.dur, oent_q.key[5:0], oent_q.key[10:6],
                          oent_q.key[15:11], oent_q.key[19:16], oent_q.key[33:20],
                          oent_q.code};
endmodule

/* design/set_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module set_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
